[src/ffsc_pkg.sv]
// Shared types, state encodings and constants for the floppy flux shift controller.
// No dependencies.
`default_nettype none
package ffsc_pkg;
    localparam int unsigned DelayWidth = 20;
    localparam logic [DelayWidth-1:0] DelayReset = 20'd1023000;

    typedef enum logic [1:0] {OP_TICK = 2'd0, OP_READ = 2'd1, OP_WRITE = 2'd2} op_t;

    localparam logic [1:0] ACT_IDLE = 2'd0;
    localparam logic [1:0] ACT_ACTIVE = 2'd1;
    localparam logic [1:0] ACT_DELAY = 2'd2;
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_READ = 2'd1;
    localparam logic [1:0] DIR_WRITE = 2'd2;
    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_EDGE0 = 3'd1;
    localparam logic [2:0] W_EDGE1 = 3'd2;
    localparam logic [2:0] W_LOAD = 3'd3;
    localparam logic [2:0] W_MIDDLE = 3'd4;
    localparam logic [2:0] W_END = 3'd5;
    localparam logic [2:0] W_UNDERRUN = 3'd6;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  ctrl;
        logic [7:0]  mode;
        logic [7:0]  status;
        logic [7:0]  data;
        logic [7:0]  hs;
        logic [7:0]  rsh;
        logic [7:0]  wsh;
        logic [1:0]  act;
        logic [1:0]  dir;
        logic [2:0]  win;
        logic [3:0]  wcnt;
        logic [3:0]  bits;
        logic [1:0]  scnt;
        logic [1:0]  acnt;
        logic [DelayWidth-1:0] dcnt;
        logic        loaded;
    } ffsc_state_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       flux_out;
        logic [3:0] phase_lines;
        logic       motor_on;
        logic [1:0] drive_select;
        logic       write_underrun;
    } ffsc_result_t;

    function automatic logic [3:0] win_size(input logic [7:0] m);
        case (m[4:3])
            2'd0: win_size = 4'd4;
            2'd1: win_size = 4'd2;
            2'd2: win_size = 4'd5;
            default: win_size = 4'd2;
        endcase
    endfunction

    function automatic logic [3:0] half_win(input logic [7:0] m);
        half_win = m[3] ? 4'd1 : 4'd2;
    endfunction
endpackage
`default_nettype wire

[src/ffsc_core.sv]
// Next-state and result logic for one item of the controller.
// Uses ffsc_pkg.
`default_nettype none
module ffsc_core (
    input  wire ffsc_pkg::ffsc_state_t  cur,
    input  wire [1:0]                   operation,
    input  wire [3:0]                   offset,
    input  wire [7:0]                   write_data,
    input  wire                         flux_in,
    input  wire                         write_protect_in,
    input  wire [ffsc_pkg::DelayWidth-1:0] delay_ticks,
    output ffsc_pkg::ffsc_state_t       nxt,
    output ffsc_pkg::ffsc_result_t      res
);
    import ffsc_pkg::*;

    always_comb
    begin
        ffsc_state_t s;
        logic [7:0] rd;
        logic pulse;
        logic [7:0] bitm;
        logic [7:0] dat;
        logic sync;
        s = cur;
        rd = 8'd0;
        pulse = 1'b0;
        bitm = 8'd0;
        sync = 1'b0;
        dat = (operation == OP_WRITE) ? write_data : 8'd0;
        if (operation == OP_TICK) begin
            if (s.act == ACT_DELAY) begin
                if (s.dcnt != '0) s.dcnt = s.dcnt - 1'b1;
                if (s.dcnt == '0) begin
                    s.act = ACT_IDLE; s.dir = DIR_IDLE; s.win = W_IDLE; s.wcnt = 4'd0;
                    s.status[5] = 1'b0; s.hs[6] = 1'b0;
                end
            end
            if (s.act == ACT_ACTIVE || s.act == ACT_DELAY) begin
                sync = !s.mode[1];
                if (s.dir == DIR_READ) begin
                    logic got;
                    got = 1'b0;
                    if (s.scnt != 2'd0) begin
                        s.scnt = s.scnt - 1'b1;
                        if (s.scnt == 2'd0 && sync) s.data = s.rsh;
                    end
                    if (s.acnt != 2'd0) begin
                        s.acnt = s.acnt - 1'b1;
                        if (s.acnt == 2'd0 && !sync) s.data = 8'd0;
                    end
                    if (s.win == W_EDGE0) begin
                        if (s.wcnt != 4'd0) s.wcnt = s.wcnt - 1'b1;
                        if (flux_in) begin
                            s.win = W_EDGE1; s.wcnt = half_win(s.mode);
                        end else if (s.wcnt == 4'd0) begin
                            s.rsh = {s.rsh[6:0], 1'b0}; s.wcnt = win_size(s.mode); got = 1'b1;
                        end
                    end else if (s.win == W_EDGE1) begin
                        if (s.wcnt != 4'd0) s.wcnt = s.wcnt - 1'b1;
                        if (s.wcnt == 4'd0) begin
                            s.rsh = {s.rsh[6:0], 1'b1}; s.win = W_EDGE0;
                            s.wcnt = win_size(s.mode); got = 1'b1;
                        end
                    end else begin
                        s.rsh = 8'd0; s.win = W_EDGE0; s.wcnt = win_size(s.mode);
                        s.scnt = 2'd0; s.acnt = 2'd0;
                    end
                    if (got) begin
                        if (sync) begin
                            if (s.rsh[7]) begin s.data = s.rsh; s.rsh = 8'd0; end
                            else if (s.rsh >= 8'h04) begin s.data = s.rsh; s.scnt = 2'd0; end
                            else if (s.rsh >= 8'h02) s.scnt = s.mode[3] ? 2'd1 : 2'd2;
                        end else if (s.rsh[7]) begin
                            s.data = s.rsh; s.acnt = 2'd0; s.rsh = 8'd0;
                        end
                    end
                end else if (s.dir == DIR_WRITE && s.hs[6]) begin
                    if (s.wcnt != 4'd0) s.wcnt = s.wcnt - 1'b1;
                    // at most two machine steps per tick
                    for (int n = 0; n < 2; n++) begin
                        if (s.wcnt == 4'd0 && s.hs[6]) begin
                            case (s.win)
                                W_LOAD:
                                begin
                                    if (s.hs[7]) begin
                                        s.hs[6] = 1'b0; s.win = W_UNDERRUN;
                                    end else begin
                                        s.wsh = s.data; s.win = W_MIDDLE; s.hs[7] = 1'b1;
                                        s.wcnt = half_win(s.mode) - 4'd1;
                                    end
                                end
                                W_MIDDLE:
                                begin
                                    if (s.wsh[7]) pulse = 1'b1;
                                    s.wsh = {s.wsh[6:0], 1'b0}; s.win = W_END;
                                    s.wcnt = half_win(s.mode);
                                end
                                W_END:
                                begin
                                    if (s.mode[1] && s.bits == 4'd1) begin
                                        s.win = W_LOAD; s.bits = 4'd8; s.wcnt = 4'd1;
                                    end else begin
                                        if (s.mode[1]) s.bits = s.bits - 4'd1;
                                        s.win = W_MIDDLE; s.wcnt = half_win(s.mode);
                                    end
                                end
                                W_UNDERRUN: s.wcnt = 4'd1;
                                default:
                                begin
                                    if (s.mode[1]) begin
                                        s.win = W_LOAD; s.bits = 4'd8; s.wcnt = 4'd1;
                                    end else begin
                                        s.wsh = s.data; s.win = W_MIDDLE;
                                        s.wcnt = half_win(s.mode);
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
        end else if (operation == OP_READ || operation == OP_WRITE) begin
            bitm = 8'd1 << offset[3:1];
            if (!offset[3]) begin
                if (offset[0]) s.phase = s.phase | bitm[3:0];
                else s.phase = s.phase & ~bitm[3:0];
            end else begin
                if (offset[0]) s.ctrl = s.ctrl | bitm;
                else s.ctrl = s.ctrl & ~bitm;
            end
            if (s.ctrl[4]) begin
                if (s.act != ACT_ACTIVE) begin
                    s.act = ACT_ACTIVE; s.dcnt = '0; s.status[5] = 1'b1;
                end
                if (!s.ctrl[7]) begin
                    if (s.dir != DIR_READ) begin
                        s.dir = DIR_READ; s.win = W_IDLE; s.wcnt = 4'd0;
                        s.scnt = 2'd0; s.acnt = 2'd0; s.data = 8'd0;
                    end
                end else if (s.dir != DIR_WRITE) begin
                    s.dir = DIR_WRITE; s.win = W_IDLE; s.wcnt = 4'd0;
                    s.hs[6] = 1'b1; s.loaded = 1'b0;
                end
            end else if (s.act == ACT_ACTIVE) begin
                if (s.mode[2]) begin
                    s.act = ACT_IDLE; s.dir = DIR_IDLE; s.win = W_IDLE; s.wcnt = 4'd0;
                    s.status[5] = 1'b0; s.hs[6] = 1'b0;
                end else begin
                    s.act = ACT_DELAY; s.dcnt = delay_ticks;
                end
            end
            if (s.ctrl[7:6] == 2'b01 && s.act == ACT_ACTIVE && s.dir == DIR_READ)
                s.rsh = 8'd0;
            if (s.act != ACT_IDLE && !s.ctrl[7] && s.mode[1] && s.data[7])
                s.acnt = 2'd2;
            if (s.ctrl[7:6] == 2'b11 && offset[0]) begin
                if (s.act != ACT_IDLE) begin
                    s.data = dat;
                    if (!s.mode[1] && s.dir == DIR_WRITE) s.wsh = dat;
                    if (s.mode[0]) begin s.hs[7] = 1'b0; s.loaded = 1'b1; end
                end else begin
                    s.mode = dat;
                    s.status = {s.status[7:5], dat[4:0]};
                end
            end
            if (operation == OP_READ) begin
                case (s.ctrl[7:6])
                    2'b00: rd = (s.act != ACT_IDLE) ? s.data : 8'hFF;
                    2'b01: rd = {write_protect_in, s.status[6:0]};
                    2'b10: rd = s.hs;
                    default: rd = 8'hFF;
                endcase
            end
        end
        nxt = s;
        res.read_data = rd;
        res.flux_out = pulse;
        res.phase_lines = s.phase;
        res.motor_on = (s.act != ACT_IDLE);
        res.drive_select = (s.act == ACT_IDLE) ? 2'd0 : (s.ctrl[5] ? 2'd2 : 2'd1);
        res.write_underrun = (s.win == W_UNDERRUN);
    end
endmodule
`default_nettype wire

[src/floppy_flux_shift_controller.sv]
// Top level of the floppy flux shift controller: state and result registers.
// Uses ffsc_pkg and ffsc_core.
//
// Takes one item per clock while in_stall is low: a controller tick (with the
// read flux bit) or a bus access to one of 16 soft-switch offsets. Each item
// yields one result item, registered, in the cycle after acceptance. A new
// item is accepted every cycle while the result register is empty or being
// taken downstream; the single result register is the only buffering, so the
// sustained rate is one item per cycle. All controller state updates in the
// same cycle the item is accepted, through one pass of ffsc_core. The user must
// write disable_delay_ticks through cfg_we/cfg_data while idle; not enforced.
`default_nettype none
module floppy_flux_shift_controller (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire [ffsc_pkg::DelayWidth-1:0] cfg_data,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire [1:0]  operation,
    input  wire [3:0]  offset,
    input  wire [7:0]  write_data,
    input  wire        flux_in,
    input  wire        write_protect_in,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] read_data,
    output logic       flux_out,
    output logic [3:0] phase_lines,
    output logic       motor_on,
    output logic [1:0] drive_select,
    output logic       write_underrun
);
    import ffsc_pkg::*;

    // everything clear except the handshake register
    localparam ffsc_state_t StateReset = '{hs: 8'hBF, default: '0};

    ffsc_state_t  st_reg, st_next;
    ffsc_result_t res_reg, res_next;
    logic [DelayWidth-1:0] delay_reg;
    logic valid_reg;
    logic take;

    assign in_stall = valid_reg && out_stall;
    assign take = in_valid && !in_stall;

    ffsc_core u_core (
        .cur(st_reg), .operation(operation), .offset(offset),
        .write_data(write_data), .flux_in(flux_in),
        .write_protect_in(write_protect_in), .delay_ticks(delay_reg),
        .nxt(st_next), .res(res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= StateReset;
            delay_reg <= DelayReset;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_we) delay_reg <= cfg_data;
            if (take) st_reg <= st_next;
            if (take) valid_reg <= 1'b1;
            else if (!out_stall) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign read_data = res_reg.read_data;
    assign flux_out = res_reg.flux_out;
    assign phase_lines = res_reg.phase_lines;
    assign motor_on = res_reg.motor_on;
    assign drive_select = res_reg.drive_select;
    assign write_underrun = res_reg.write_underrun;

    a_idle_dir: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.act == ACT_IDLE |-> st_reg.dir == DIR_IDLE) else $error("dir not idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(st_reg)) else $error("state moved without item");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid) else $error("result lost");
endmodule
`default_nettype wire
